// ===== src/sps_pkg.sv =====
// shared types and constants for the strict priority thread scheduler
`timescale 1ns / 1ps
package sps_pkg;
   localparam logic [1:0] ST_STOPPED  = 2'd0;
   localparam logic [1:0] ST_RUNNABLE = 2'd1;
   localparam logic [1:0] ST_WAITING  = 2'd2;
   localparam logic [1:0] ST_RUNNING  = 2'd3;

   localparam logic [2:0] MODE_START = 3'd0;
   localparam logic [2:0] MODE_STOP  = 3'd1;
   localparam logic [2:0] MODE_PRIO  = 3'd2;
   localparam logic [2:0] MODE_YIELD = 3'd3;
   localparam logic [2:0] MODE_BLOCK = 3'd4;
   localparam logic [2:0] MODE_WAKE  = 3'd5;

   typedef struct packed {
      logic [2:0] mode;
      logic [4:0] thread_index;
      logic       target_is_running;
      logic [7:0] new_priority;
   } req_type;

   typedef struct packed {
      logic [4:0] running_thread;
      logic       running_valid;
      logic       switched;
      logic [1:0] target_state;
      logic       ignored;
   } rsp_type;
endpackage

// ===== src/strict_priority_thread_scheduler_core.sv =====
// top level: event sequencer over a chain of thread slot cells
`timescale 1ns / 1ps
// One event is taken while busy is low. Its single result appears with
// rsp_valid some cycles later, for one cycle, and the receiver cannot stall.
// Busy falls in the same cycle as the result strobe. Each head lookup is
// one load step plus a scan that ripples one slot per cycle down the cell
// chain. An event needs up to two lookups plus six control steps: decode,
// two head checks, the requeue of a preempted thread, idle pickup and output.
module strict_priority_thread_scheduler_core
   import sps_pkg::*;
#(
   parameter int NUM_THREADS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);
   localparam int RW = $clog2(NUM_THREADS + 1);
   localparam int IW = (NUM_THREADS > 2) ? $clog2(NUM_THREADS) : 1;

   typedef enum logic [7:0] {
      S_IDLE = 8'b00000001,
      S_EXEC = 8'b00000010,
      S_REQ  = 8'b00000100,
      S_SCAN = 8'b00001000,
      S_HEAD = 8'b00010000,
      S_DISP = 8'b00100000,
      S_FIN  = 8'b01000000,
      S_OUT  = 8'b10000000
   } fsm_type;

   // what to do once the scan result is in
   typedef enum logic [1:0] {
      H_DISPATCH = 2'd0,
      H_PRIOCHK  = 2'd1
   } hact_type;

   fsm_type       st_ff;
   hact_type      hact_ff;
   req_type       req_ff;
   logic [RW-1:0] cnt_ff;
   logic [IW-1:0] cur_ff;
   logic          has_ff, had_ff;
   logic [IW-1:0] was_ff;
   logic          have_t_ff, ign_ff;
   logic [IW-1:0] t_ff;
   logic [RW-1:0] scnt_ff;
   logic          rv_ff;
   rsp_type       rsp_ff;

   // cell wiring
   logic [7:0]    c_prio [NUM_THREADS];
   logic [1:0]    c_state[NUM_THREADS];
   logic [RW-1:0] c_rank [NUM_THREADS];
   logic          ch_v [NUM_THREADS+1];
   logic [7:0]    ch_p [NUM_THREADS+1];
   logic [RW-1:0] ch_r [NUM_THREADS+1];
   logic [RW-1:0] ch_i [NUM_THREADS+1];
   logic [NUM_THREADS-1:0] wr_en;
   logic [7:0]    wr_prio [NUM_THREADS];
   logic [1:0]    wr_state[NUM_THREADS];
   logic [RW-1:0] wr_rank [NUM_THREADS];
   logic          dec_en;
   logic [RW-1:0] dec_above;

   assign ch_v[0] = 1'b0;
   assign ch_p[0] = '0;
   assign ch_r[0] = '0;
   assign ch_i[0] = '0;

   for (genvar g = 0; g < NUM_THREADS; g++) begin : g_cell
      sps_cell #(.RW(RW)) u_cell (
         .clock(clock), .reset(reset),
         .wr_en(wr_en[g]), .wr_prio(wr_prio[g]), .wr_state(wr_state[g]),
         .wr_rank(wr_rank[g]),
         .dec_en(dec_en), .dec_above(dec_above),
         .scan_in_v(ch_v[g]), .scan_in_p(ch_p[g]), .scan_in_r(ch_r[g]),
         .scan_in_i(ch_i[g]), .my_index(RW'(g)),
         .scan_out_v(ch_v[g+1]), .scan_out_p(ch_p[g+1]), .scan_out_r(ch_r[g+1]),
         .scan_out_i(ch_i[g+1]),
         .prio(c_prio[g]), .state(c_state[g]), .rank(c_rank[g])
      );
   end

   logic          hv;
   logic [7:0]    hp;
   logic [IW-1:0] hi;
   assign hv = ch_v[NUM_THREADS];
   assign hp = ch_p[NUM_THREADS];
   assign hi = ch_i[NUM_THREADS][IW-1:0];

   logic [7:0]    tp, cp;
   logic [1:0]    ts;
   logic [RW-1:0] tr;
   assign tp = c_prio[t_ff];
   assign ts = c_state[t_ff];
   assign tr = c_rank[t_ff];
   assign cp = c_prio[cur_ff];

   fsm_type       st_in;
   hact_type      hact_in;
   logic [RW-1:0] cnt_in, scnt_in;
   logic [IW-1:0] cur_in, t_in;
   logic          has_in, have_t_in, ign_in;

   // target selection for the incoming transaction
   logic          sel_v;
   logic [IW-1:0] sel_t;
   always_comb begin
      sel_v = 1'b0;
      sel_t = cur_ff;
      if (req_data.mode <= MODE_PRIO || req_data.mode == MODE_WAKE) begin
         if (req_data.target_is_running) begin
            sel_v = has_ff;
         end else if (32'(req_data.thread_index) < NUM_THREADS) begin
            sel_v = 1'b1;
            sel_t = IW'(req_data.thread_index);
         end
      end else if (req_data.mode == MODE_YIELD || req_data.mode == MODE_BLOCK) begin
         sel_v = has_ff;
      end
   end

   // sequencer: each step does at most one slot write plus one rank decrement
   always_comb begin
      st_in     = st_ff;
      hact_in   = hact_ff;
      cnt_in    = cnt_ff;
      scnt_in   = scnt_ff;
      cur_in    = cur_ff;
      t_in      = t_ff;
      has_in    = has_ff;
      have_t_in = have_t_ff;
      ign_in    = ign_ff;
      wr_en     = '0;
      dec_en    = 1'b0;
      dec_above = '0;
      for (int k = 0; k < NUM_THREADS; k++) begin
         wr_prio[k]  = c_prio[k];
         wr_state[k] = c_state[k];
         wr_rank[k]  = c_rank[k];
      end
      case (st_ff)
         S_IDLE: begin
            if (start) begin
               t_in      = sel_t;
               have_t_in = sel_v;
               ign_in    = 1'b1;
               st_in     = sel_v ? S_EXEC : S_FIN;
            end
         end
         S_EXEC: begin
            st_in = S_FIN;
            case (req_ff.mode)
               MODE_START: begin
                  if (ts != ST_RUNNING) begin
                     ign_in = 1'b0;
                     // remove then append; rank decrement runs beside the write
                     if (ts == ST_RUNNABLE) begin
                        dec_en    = 1'b1;
                        dec_above = tr;
                     end
                     wr_en[t_ff]    = 1'b1;
                     wr_state[t_ff] = ST_RUNNABLE;
                     wr_rank[t_ff]  = (ts == ST_RUNNABLE) ? cnt_ff - 1'b1 : cnt_ff;
                     cnt_in = (ts == ST_RUNNABLE) ? cnt_ff : cnt_ff + 1'b1;
                     if (!has_ff || tp > cp) begin
                        st_in = S_REQ;
                        if (has_ff) begin
                           st_in = S_DISP;
                           hact_in = H_DISPATCH;
                        end
                     end
                  end
               end
               MODE_STOP: begin
                  if (ts != ST_STOPPED) begin
                     ign_in = 1'b0;
                     wr_en[t_ff]    = 1'b1;
                     wr_state[t_ff] = ST_STOPPED;
                     if (ts == ST_RUNNABLE) begin
                        dec_en    = 1'b1;
                        dec_above = tr;
                        cnt_in    = cnt_ff - 1'b1;
                     end
                     if (ts == ST_RUNNING) begin
                        has_in = 1'b0;
                     end
                  end
               end
               MODE_PRIO: begin
                  if (tp != req_ff.new_priority) begin
                     ign_in = 1'b0;
                     wr_en[t_ff]   = 1'b1;
                     wr_prio[t_ff] = req_ff.new_priority;
                     if (ts == ST_RUNNABLE) begin
                        dec_en        = 1'b1;
                        dec_above     = tr;
                        wr_rank[t_ff] = cnt_ff - 1'b1;
                     end else if (ts == ST_RUNNING) begin
                        if (req_ff.new_priority == 8'd0) begin
                           wr_state[t_ff] = ST_WAITING;
                           has_in = 1'b0;
                        end else begin
                           hact_in = H_PRIOCHK;
                           st_in   = S_REQ;
                        end
                     end
                  end
               end
               MODE_YIELD: begin
                  ign_in = 1'b0;
                  wr_en[t_ff]    = 1'b1;
                  wr_state[t_ff] = ST_RUNNABLE;
                  wr_rank[t_ff]  = cnt_ff;
                  cnt_in = cnt_ff + 1'b1;
                  has_in = 1'b0;
               end
               MODE_BLOCK: begin
                  ign_in = 1'b0;
                  wr_en[t_ff]    = 1'b1;
                  wr_state[t_ff] = ST_WAITING;
                  has_in = 1'b0;
               end
               MODE_WAKE: begin
                  if (ts == ST_STOPPED || ts == ST_WAITING) begin
                     ign_in = 1'b0;
                     wr_en[t_ff]    = 1'b1;
                     wr_state[t_ff] = ST_RUNNABLE;
                     wr_rank[t_ff]  = cnt_ff;
                     cnt_in = cnt_ff + 1'b1;
                  end
               end
               default: ;
            endcase
         end
         S_DISP: begin
            // requeue the preempted running thread behind its equals
            wr_en[cur_ff]    = 1'b1;
            wr_state[cur_ff] = ST_RUNNABLE;
            wr_rank[cur_ff]  = cnt_ff;
            cnt_in = cnt_ff + 1'b1;
            has_in = 1'b0;
            hact_in = H_DISPATCH;
            st_in  = S_REQ;
         end
         S_REQ: begin
            scnt_in = '0;
            st_in   = S_SCAN;
         end
         S_SCAN: begin
            scnt_in = scnt_ff + 1'b1;
            if (scnt_ff == RW'(NUM_THREADS)) st_in = S_HEAD;
         end
         S_HEAD: begin
            if (hact_ff == H_PRIOCHK) begin
               if (hv && hp > c_prio[cur_ff]) begin
                  st_in = S_DISP;
               end else begin
                  st_in = S_FIN;
               end
            end else begin
               st_in = S_FIN;
               if (hv && hp != 8'd0) begin
                  wr_en[hi]    = 1'b1;
                  wr_state[hi] = ST_RUNNING;
                  dec_en       = 1'b1;
                  dec_above    = c_rank[hi];
                  cnt_in       = cnt_ff - 1'b1;
                  cur_in       = hi;
                  has_in       = 1'b1;
               end else begin
                  has_in = 1'b0;
                  st_in  = S_OUT;
               end
            end
         end
         S_FIN: begin
            // idle pickup
            if (!has_ff) begin
               hact_in = H_DISPATCH;
               st_in   = S_REQ;
            end else begin
               st_in = S_OUT;
            end
         end
         S_OUT: st_in = S_IDLE;
         default: st_in = S_IDLE;
      endcase
   end

   // a dispatch that ran from S_FIN must not loop: S_HEAD goes to S_FIN,
   // which then sees has set and leaves; an empty queue goes straight out

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= S_IDLE;
         cnt_ff  <= '0;
         cur_ff  <= '0;
         has_ff  <= 1'b0;
         rv_ff   <= 1'b0;
         hact_ff <= H_DISPATCH;
      end else begin
         st_ff   <= st_in;
         cnt_ff  <= cnt_in;
         cur_ff  <= cur_in;
         has_ff  <= has_in;
         hact_ff <= hact_in;
         rv_ff   <= (st_ff == S_OUT);
      end
      scnt_ff   <= scnt_in;
      t_ff      <= t_in;
      have_t_ff <= have_t_in;
      ign_ff    <= ign_in;
      if (st_ff == S_IDLE && start) begin
         req_ff <= req_data;
         had_ff <= has_ff;
         was_ff <= cur_ff;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (st_ff == S_OUT) begin
         rsp_ff.running_thread <= has_ff ? 5'(cur_ff) : 5'd0;
         rsp_ff.running_valid  <= has_ff;
         rsp_ff.switched       <= (had_ff != has_ff) || (has_ff && was_ff != cur_ff);
         rsp_ff.target_state   <= have_t_ff ? ts : ST_STOPPED;
         rsp_ff.ignored        <= ign_ff;
      end
   end

   assign busy      = (st_ff != S_IDLE);
   assign rsp_valid = rv_ff;
   assign rsp_data  = rsp_ff;

   // the count of runnable slots never exceeds the slot count
   a_cnt: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= RW'(NUM_THREADS)) else $error("runnable count overflow");
   // a result follows in the cycle after the output step
   a_rsp: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_OUT) |=> rsp_valid) else $error("missing result");
   // the running slot is marked running in its cell
   a_cur: assert property (@(posedge clock) disable iff (reset)
      (st_ff == S_IDLE && has_ff) |-> c_state[cur_ff] == ST_RUNNING)
      else $error("running slot state mismatch");
   // a result strobe is never seen straight out of the idle state
   a_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !$past(st_ff == S_IDLE)) else $error("result without work");
endmodule

// ===== src/sps_cell.sv =====
// one thread slot: holds priority, state and arrival rank, scans through a chain
`timescale 1ns / 1ps
module sps_cell
   import sps_pkg::*;
#(
   parameter int RW = 8
) (
   input  logic          clock,
   input  logic          reset,
   // direct updates from the controller
   input  logic          wr_en,
   input  logic [7:0]    wr_prio,
   input  logic [1:0]    wr_state,
   input  logic [RW-1:0] wr_rank,
   // decrement rank if runnable and above the given rank
   input  logic          dec_en,
   input  logic [RW-1:0] dec_above,
   // scan chain: best candidate so far passes along
   input  logic          scan_in_v,
   input  logic [7:0]    scan_in_p,
   input  logic [RW-1:0] scan_in_r,
   input  logic [RW-1:0] scan_in_i,
   input  logic [RW-1:0] my_index,
   output logic          scan_out_v,
   output logic [7:0]    scan_out_p,
   output logic [RW-1:0] scan_out_r,
   output logic [RW-1:0] scan_out_i,
   output logic [7:0]    prio,
   output logic [1:0]    state,
   output logic [RW-1:0] rank
);
   logic [7:0]    prio_ff;
   logic [1:0]    state_ff;
   logic [RW-1:0] rank_ff;
   logic          sv_ff;
   logic [7:0]    sp_ff;
   logic [RW-1:0] sr_ff, si_ff;
   logic          take;

   assign prio  = prio_ff;
   assign state = state_ff;
   assign rank  = rank_ff;

   // slot storage
   always_ff @(posedge clock) begin
      if (reset) begin
         prio_ff  <= '0;
         state_ff <= ST_STOPPED;
         rank_ff  <= '0;
      end else if (wr_en) begin
         prio_ff  <= wr_prio;
         state_ff <= wr_state;
         rank_ff  <= wr_rank;
      end else if (dec_en && state_ff == ST_RUNNABLE && rank_ff > dec_above) begin
         rank_ff  <= rank_ff - 1'b1;
      end
   end

   // compare against the candidate handed in from the neighbor
   assign take = (state_ff == ST_RUNNABLE) &&
                 (!scan_in_v || prio_ff > scan_in_p ||
                  (prio_ff == scan_in_p && rank_ff < scan_in_r));

   always_ff @(posedge clock) begin
      if (reset) begin
         sv_ff <= 1'b0;
      end else begin
         sv_ff <= scan_in_v || take;
      end
      sp_ff <= take ? prio_ff  : scan_in_p;
      sr_ff <= take ? rank_ff  : scan_in_r;
      si_ff <= take ? my_index : scan_in_i;
   end

   assign scan_out_v = sv_ff;
   assign scan_out_p = sp_ff;
   assign scan_out_r = sr_ff;
   assign scan_out_i = si_ff;
endmodule

// ===== tb/sv/sps_event_checker.sv =====
// checker: predicts scheduler results from accepted events and compares them
`timescale 1ns / 1ps
module sps_event_checker
   import sps_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   output int      fail_count,
   output int      pending_count,
   output int      result_count
);
   localparam int NT = 32;

   logic [7:0] prio_tab [NT];
   logic [1:0] state_tab [NT];
   int         rank_tab [NT];
   int         queue_len;
   logic [4:0] cur_slot;
   logic       cur_valid;
   rsp_type    sched_expected [$];

   // take a slot out of the run queue
   function automatic void rq_remove(int t);
      if (state_tab[t] != ST_RUNNABLE) return;
      for (int i = 0; i < NT; i++)
         if (state_tab[i] == ST_RUNNABLE && rank_tab[i] > rank_tab[t]) rank_tab[i]--;
      if (queue_len > 0) queue_len--;
      state_tab[t] = ST_STOPPED;
   endfunction

   function automatic void rq_push(int t);
      state_tab[t] = ST_RUNNABLE;
      rank_tab[t] = queue_len;
      queue_len++;
   endfunction

   function automatic int rq_head();
      int best;
      best = -1;
      for (int i = 0; i < NT; i++) begin
         if (state_tab[i] != ST_RUNNABLE) continue;
         if (best < 0 || prio_tab[i] > prio_tab[best] ||
             (prio_tab[i] == prio_tab[best] && rank_tab[i] < rank_tab[best]))
            best = i;
      end
      return best;
   endfunction

   function automatic void dispatch_head();
      int h;
      h = rq_head();
      if (h >= 0 && prio_tab[h] > 0) begin
         rq_remove(h);
         state_tab[h] = ST_RUNNING;
         cur_slot = h[4:0];
         cur_valid = 1'b1;
      end else
         cur_valid = 1'b0;
   endfunction

   // apply one event to the shadow scheduler and return its result
   function automatic rsp_type schedule_event(req_type rq);
      rsp_type r;
      logic had, have_t, ign;
      logic [4:0] was;
      int t, h;
      had = cur_valid; was = cur_slot; have_t = 0; t = 0; ign = 1;
      if (rq.mode <= MODE_PRIO || rq.mode == MODE_WAKE) begin
         if (rq.target_is_running) begin
            if (cur_valid) begin t = cur_slot; have_t = 1; end
         end else begin
            t = rq.thread_index; have_t = 1;
         end
      end else if (rq.mode == MODE_YIELD || rq.mode == MODE_BLOCK) begin
         if (cur_valid) begin t = cur_slot; have_t = 1; end
      end
      if (have_t) begin
         case (rq.mode)
            MODE_START: if (state_tab[t] != ST_RUNNING) begin
               ign = 0;
               rq_remove(t);
               rq_push(t);
               if (!cur_valid || prio_tab[t] > prio_tab[cur_slot]) begin
                  if (cur_valid) rq_push(cur_slot);
                  cur_valid = 0;
                  dispatch_head();
               end
            end
            MODE_STOP: if (state_tab[t] != ST_STOPPED) begin
               ign = 0;
               if (state_tab[t] == ST_RUNNING) begin
                  state_tab[t] = ST_STOPPED;
                  cur_valid = 0;
                  dispatch_head();
               end else begin
                  rq_remove(t);
                  state_tab[t] = ST_STOPPED;
               end
            end
            MODE_PRIO: if (prio_tab[t] != rq.new_priority) begin
               ign = 0;
               prio_tab[t] = rq.new_priority;
               if (state_tab[t] == ST_RUNNABLE) begin
                  rq_remove(t);
                  rq_push(t);
               end else if (state_tab[t] == ST_RUNNING) begin
                  if (rq.new_priority == 0) begin
                     state_tab[t] = ST_WAITING;
                     cur_valid = 0;
                     dispatch_head();
                  end else begin
                     h = rq_head();
                     if (h >= 0 && prio_tab[h] > rq.new_priority) begin
                        rq_push(t);
                        cur_valid = 0;
                        dispatch_head();
                     end
                  end
               end
            end
            MODE_YIELD: begin
               ign = 0;
               rq_push(t);
               cur_valid = 0;
               dispatch_head();
            end
            MODE_BLOCK: begin
               ign = 0;
               state_tab[t] = ST_WAITING;
               cur_valid = 0;
               dispatch_head();
            end
            MODE_WAKE: if (state_tab[t] != ST_RUNNING && state_tab[t] != ST_RUNNABLE) begin
               ign = 0;
               rq_push(t);
            end
            default: ;
         endcase
      end
      if (!cur_valid) dispatch_head();
      r.running_thread = cur_valid ? cur_slot : 5'd0;
      r.running_valid  = cur_valid;
      r.switched       = (had != cur_valid) || (cur_valid && was != cur_slot);
      r.target_state   = have_t ? state_tab[t] : ST_STOPPED;
      r.ignored        = ign;
      return r;
   endfunction

   assign pending_count = sched_expected.size();

   // predict on accepted events, compare on result strobes
   always @(posedge clock) begin
      rsp_type e;
      if (reset) begin
         for (int i = 0; i < NT; i++) begin
            prio_tab[i] <= 0; state_tab[i] <= ST_STOPPED; rank_tab[i] <= 0;
         end
         queue_len <= 0; cur_slot <= 0; cur_valid <= 0;
         fail_count <= 0; result_count <= 0;
         sched_expected.delete();
      end else begin
         if (rsp_valid) begin
            result_count <= result_count + 1;
            if (sched_expected.size() == 0) begin
               $error("unexpected result transaction %p", rsp_data);
               fail_count <= fail_count + 1;
            end else begin
               e = sched_expected.pop_front();
               if (e !== rsp_data) begin
                  if (e.running_thread !== rsp_data.running_thread)
                     $error("running_thread expected %0d actual %0d",
                            e.running_thread, rsp_data.running_thread);
                  if (e.running_valid !== rsp_data.running_valid)
                     $error("running_valid expected %0d actual %0d",
                            e.running_valid, rsp_data.running_valid);
                  if (e.switched !== rsp_data.switched)
                     $error("switched expected %0d actual %0d",
                            e.switched, rsp_data.switched);
                  if (e.target_state !== rsp_data.target_state)
                     $error("target_state expected %0d actual %0d",
                            e.target_state, rsp_data.target_state);
                  if (e.ignored !== rsp_data.ignored)
                     $error("ignored expected %0d actual %0d",
                            e.ignored, rsp_data.ignored);
                  fail_count <= fail_count + 1;
               end
            end
         end
         if (start && !busy) sched_expected.push_back(schedule_event(req_data));
      end
   end
endmodule

// ===== tb/sv/tb_strict_priority_thread_scheduler_core.sv =====
// testbench top: drives scheduler events and reports the verdict
`timescale 1ns / 1ps
module tb_strict_priority_thread_scheduler_core;
   import sps_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      fail_count, pending_count, result_count;
   int      cycle_count = 0;
   int      sent_count = 0;

   localparam int CYCLE_LIMIT = 600000;

   always #5 clock = ~clock;

   strict_priority_thread_scheduler_core #(.NUM_THREADS(32)) u_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data));

   sps_event_checker u_checker (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .fail_count(fail_count), .pending_count(pending_count),
      .result_count(result_count));

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("** strict_priority_thread_scheduler_core: FAILED **");
         $finish;
      end
   end

   // present one transaction and hold it until accepted; start stays high
   // afterwards and is dropped by the next idle cycle or by the caller
   task automatic send_event(input logic [2:0] m, input logic [4:0] idx,
                             input logic tir, input logic [7:0] np, input bit may_idle);
      while (may_idle && $urandom_range(99) < 32) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_data <= '{mode: m, thread_index: idx, target_is_running: tir, new_priority: np};
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_count++;
   endtask

   // stop sending and wait until every expected result has come
   task automatic drain();
      start <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // random event biased toward a small set of busy threads
   task automatic random_event(input bit may_idle);
      logic [2:0] m;
      logic [4:0] idx;
      logic [7:0] np;
      m = $urandom_range(99) < 95 ? 3'($urandom_range(5)) : 3'($urandom_range(7, 6));
      idx = $urandom_range(3) == 0 ? 5'($urandom) : 5'($urandom_range(7));
      case ($urandom_range(4))
         0: np = 8'($urandom);
         1: np = 0;
         2: np = 255;
         default: np = 8'($urandom_range(1, 4));
      endcase
      send_event(m, idx, $urandom_range(5) == 0, np, may_idle);
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: events with nothing running, priorities at extremes
      send_event(MODE_YIELD, 0, 0, 0, 0);
      send_event(MODE_BLOCK, 0, 0, 0, 0);
      send_event(MODE_PRIO, 0, 1, 9, 0);
      send_event(MODE_START, 3, 0, 0, 0);
      send_event(MODE_PRIO, 3, 0, 5, 0);
      send_event(MODE_PRIO, 3, 0, 5, 0);
      send_event(MODE_START, 7, 0, 0, 0);
      send_event(MODE_PRIO, 7, 0, 255, 0);
      send_event(MODE_START, 31, 0, 0, 0);
      send_event(MODE_PRIO, 31, 0, 255, 0);
      send_event(MODE_START, 31, 0, 0, 0);
      send_event(MODE_START, 7, 1, 0, 0);
      send_event(MODE_YIELD, 0, 0, 0, 0);
      send_event(MODE_PRIO, 0, 1, 1, 0);
      send_event(MODE_PRIO, 0, 1, 0, 0);
      send_event(MODE_WAKE, 7, 0, 0, 0);
      send_event(MODE_WAKE, 7, 0, 0, 0);
      send_event(MODE_BLOCK, 0, 0, 0, 0);
      send_event(MODE_STOP, 3, 0, 0, 0);
      send_event(MODE_STOP, 3, 0, 0, 0);
      send_event(MODE_STOP, 0, 1, 0, 0);
      send_event(3'd6, 5, 1, 200, 0);
      send_event(3'd7, 5, 0, 17, 0);
      // random, with an unthrottled stretch and a drain pause
      for (int n = 0; n < 1200; n++) begin
         if (n == 600) begin
            drain();
            repeat (80) @(posedge clock);
         end
         random_event(!(n >= 300 && n < 450));
      end
      drain();
      repeat (100) @(posedge clock);
      $display("sent %0d scheduler events, checked %0d results", sent_count, result_count);
      $display("covered start/stop/priority/yield/block/wake, unused modes and idle cases");
      if (fail_count == 0)
         $display("** strict_priority_thread_scheduler_core: PASSED **");
      else
         $display("** strict_priority_thread_scheduler_core: FAILED **");
      $finish;
   end
endmodule
